### src/c_subset_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
// No dependencies; included by the files that check their own logic.
`ifndef C_SUBSET_TOKENIZER_ASSERT_SVH
`define C_SUBSET_TOKENIZER_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define CST_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define CST_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// A condition that implies another in the next cycle.
`define CST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/cst_pkg.sv
// Shared constants, tables and small decode functions of the tokenizer.
// No dependencies; used by every module of the block.
package cst_pkg;

  // Token kind codes.
  localparam int KIND_W = 6;
  localparam logic [KIND_W-1:0] KIND_EOF     = 6'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT   = 6'd1;
  localparam logic [KIND_W-1:0] KIND_INT     = 6'd2;
  localparam logic [KIND_W-1:0] KIND_KW0     = 6'd3;
  localparam logic [KIND_W-1:0] KIND_INCR    = 6'd14;
  localparam logic [KIND_W-1:0] KIND_PLUS    = 6'd15;
  localparam logic [KIND_W-1:0] KIND_DECR    = 6'd16;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 6'd17;
  localparam logic [KIND_W-1:0] KIND_STAR    = 6'd18;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 6'd19;
  localparam logic [KIND_W-1:0] KIND_PERCENT = 6'd20;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 6'd21;
  localparam logic [KIND_W-1:0] KIND_SEMI    = 6'd22;
  localparam logic [KIND_W-1:0] KIND_LPAREN  = 6'd23;
  localparam logic [KIND_W-1:0] KIND_RPAREN  = 6'd24;
  localparam logic [KIND_W-1:0] KIND_LBRACE  = 6'd25;
  localparam logic [KIND_W-1:0] KIND_RBRACE  = 6'd26;
  localparam logic [KIND_W-1:0] KIND_LBRACK  = 6'd27;
  localparam logic [KIND_W-1:0] KIND_RBRACK  = 6'd28;
  localparam logic [KIND_W-1:0] KIND_EQEQ    = 6'd29;
  localparam logic [KIND_W-1:0] KIND_ASSIGN  = 6'd30;
  localparam logic [KIND_W-1:0] KIND_GE      = 6'd31;
  localparam logic [KIND_W-1:0] KIND_GT      = 6'd32;
  localparam logic [KIND_W-1:0] KIND_LE      = 6'd33;
  localparam logic [KIND_W-1:0] KIND_LT      = 6'd34;
  localparam logic [KIND_W-1:0] KIND_NE      = 6'd35;
  localparam logic [KIND_W-1:0] KIND_NOT     = 6'd36;
  localparam logic [KIND_W-1:0] KIND_LAND    = 6'd37;
  localparam logic [KIND_W-1:0] KIND_AMP     = 6'd38;
  localparam logic [KIND_W-1:0] KIND_LOR     = 6'd39;
  localparam logic [KIND_W-1:0] KIND_BAR     = 6'd40;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 6'd41;

  // Pending token modes; operator modes run from MODE_OP0 upward.
  localparam int MODE_W = 4;
  localparam logic [MODE_W-1:0] MODE_IDLE   = 4'd0;
  localparam logic [MODE_W-1:0] MODE_IDENT  = 4'd1;
  localparam logic [MODE_W-1:0] MODE_NUMBER = 4'd2;
  localparam logic [MODE_W-1:0] MODE_OP0    = 4'd3;

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Keyword table, each word right-justified with its first byte highest.
  localparam int NKW = 11;
  localparam logic [47:0] KW_TEXT [NKW] = '{
    48'("int"), 48'("bool"), 48'("void"), 48'("return"), 48'("if"), 48'("else"),
    48'("while"), 48'("for"), 48'("const"), 48'("true"), 48'("false")
  };
  localparam logic [2:0] KW_LEN [NKW] = '{3'd3, 3'd4, 3'd4, 3'd6, 3'd2, 3'd4,
                                          3'd5, 3'd3, 3'd5, 3'd4, 3'd5};

  // Token queue between the lexer and the output stage.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } pair_hit_t;

  // Byte i of keyword k; zero past its end.
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] i);
    logic [47:0] w;
    int          sh;
    w  = KW_TEXT[k];
    sh = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
    if (sh < 0) begin
      return 8'h00;
    end
    return w[sh +: 8];
  endfunction

  // Operators that may take a second byte.
  function automatic pair_hit_t pair_lookup(input logic [7:0] c);
    pair_hit_t r;
    r.hit = 1'b1;
    case (c)
      "+":     r.idx = 3'd0;
      "-":     r.idx = 3'd1;
      "=":     r.idx = 3'd2;
      ">":     r.idx = 3'd3;
      "<":     r.idx = 3'd4;
      "!":     r.idx = 3'd5;
      "&":     r.idx = 3'd6;
      "|":     r.idx = 3'd7;
      default: begin
        r.hit = 1'b0;
        r.idx = 3'd0;
      end
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pair_second(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = "+";
      3'd1:    r = "-";
      3'd6:    r = "&";
      3'd7:    r = "|";
      default: r = "=";
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] pair_double(input logic [2:0] idx);
    logic [KIND_W-1:0] r;
    case (idx)
      3'd0:    r = KIND_INCR;
      3'd1:    r = KIND_DECR;
      3'd2:    r = KIND_EQEQ;
      3'd3:    r = KIND_GE;
      3'd4:    r = KIND_LE;
      3'd5:    r = KIND_NE;
      3'd6:    r = KIND_LAND;
      default: r = KIND_LOR;
    endcase
    return r;
  endfunction

  function automatic logic [KIND_W-1:0] pair_single(input logic [2:0] idx);
    logic [KIND_W-1:0] r;
    case (idx)
      3'd0:    r = KIND_PLUS;
      3'd1:    r = KIND_MINUS;
      3'd2:    r = KIND_ASSIGN;
      3'd3:    r = KIND_GT;
      3'd4:    r = KIND_LT;
      3'd5:    r = KIND_NOT;
      3'd6:    r = KIND_AMP;
      default: r = KIND_BAR;
    endcase
    return r;
  endfunction

  // Operators that always stand alone; anything else is unknown.
  function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
    logic [KIND_W-1:0] r;
    case (c)
      "*":     r = KIND_STAR;
      "/":     r = KIND_SLASH;
      "%":     r = KIND_PERCENT;
      ",":     r = KIND_COMMA;
      ";":     r = KIND_SEMI;
      "(":     r = KIND_LPAREN;
      ")":     r = KIND_RPAREN;
      "{":     r = KIND_LBRACE;
      "}":     r = KIND_RBRACE;
      "[":     r = KIND_LBRACK;
      "]":     r = KIND_RBRACK;
      default: r = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

endpackage

### src/cst_front.sv
// Lexer front end: takes one byte per word and builds the bundle of up to
// three tokens it causes. Depends on cst_pkg and the assertion macro header.
`include "c_subset_tokenizer_assert.svh"

module cst_front #(
  parameter int LENGTH_BITS   = 12,
  parameter int POSITION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic [7:0]            in_ch,
  input  logic                  in_last,
  output logic                  in_ready,
  input  cst_pkg::q_status_t    q_status,
  output logic                  push,
  output logic [2+3*(cst_pkg::KIND_W+LENGTH_BITS+2*POSITION_BITS)-1:0] bundle
);

  typedef struct packed {
    logic [cst_pkg::KIND_W-1:0] kind;
    logic [LENGTH_BITS-1:0]     len;
    logic [POSITION_BITS-1:0]   line;
    logic [POSITION_BITS-1:0]   col;
  } tok_t;

  typedef struct packed {
    logic [1:0]     cnt;
    tok_t [2:0]     tok;
  } bundle_t;

  // Kind of a pending token when it is flushed.
  function automatic logic [cst_pkg::KIND_W-1:0] pending_kind(
    input logic [cst_pkg::MODE_W-1:0] m,
    input logic [cst_pkg::NKW-1:0]    cd,
    input logic [LENGTH_BITS-1:0]     ln
  );
    logic [cst_pkg::KIND_W-1:0] r;
    r = cst_pkg::pair_single(3'(m - cst_pkg::MODE_OP0));
    if (m == cst_pkg::MODE_NUMBER) begin
      r = cst_pkg::KIND_INT;
    end else if (m == cst_pkg::MODE_IDENT) begin
      r = cst_pkg::KIND_IDENT;
      for (int k = 0; k < cst_pkg::NKW; k++) begin
        if (cd[k] && ln == LENGTH_BITS'(cst_pkg::KW_LEN[k])) begin
          r = cst_pkg::KIND_KW0 + cst_pkg::KIND_W'(k);
        end
      end
    end
    return r;
  endfunction

  // Lexer state.
  logic [cst_pkg::MODE_W-1:0] mode;
  logic [cst_pkg::NKW-1:0]    cand;
  logic [LENGTH_BITS-1:0]     plen;
  logic [POSITION_BITS-1:0]   line;
  logic [POSITION_BITS-1:0]   col;
  logic                       ended;

  logic                       accept;
  logic                       is_alpha, is_digit, is_space, id_start, id_cont;
  cst_pkg::pair_hit_t         ph;
  logic                       is_op, cont, dbl, nul, fresh;
  logic                       start_ident, start_num, start_op, single_tok;
  logic [2:0]                 op_idx;
  logic [cst_pkg::NKW-1:0]    base_cand, cand_n;
  logic [LENGTH_BITS-1:0]     base_len, len_inc;
  logic [cst_pkg::MODE_W-1:0] mode_next;
  logic [cst_pkg::NKW-1:0]    cand_next;
  logic [LENGTH_BITS-1:0]     plen_next;
  logic [POSITION_BITS-1:0]   line_next, col_next;
  tok_t                       t [4];
  logic [3:0]                 v;
  bundle_t                    b;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;

  // Byte classes.
  always_comb begin
    is_alpha = (in_ch >= "a" && in_ch <= "z") || (in_ch >= "A" && in_ch <= "Z");
    is_digit = in_ch >= "0" && in_ch <= "9";
    is_space = in_ch == " " || (in_ch >= 8'd9 && in_ch <= 8'd13);
    id_start = is_alpha || in_ch == "_";
    id_cont  = id_start || is_digit;
    ph       = cst_pkg::pair_lookup(in_ch);
  end

  // What the byte does to the pending token.
  always_comb begin
    is_op       = mode >= cst_pkg::MODE_OP0;
    op_idx      = 3'(mode - cst_pkg::MODE_OP0);
    cont        = (mode == cst_pkg::MODE_IDENT && id_cont) ||
                  (mode == cst_pkg::MODE_NUMBER && is_digit);
    dbl         = is_op && in_ch == cst_pkg::pair_second(op_idx);
    nul         = !cont && !dbl && in_ch == cst_pkg::CH_NUL;
    fresh       = !cont && !dbl && !nul;
    start_ident = fresh && id_start;
    start_num   = fresh && is_digit;
    start_op    = fresh && ph.hit;
    single_tok  = fresh && !is_space && !id_start && !is_digit && !ph.hit;
  end

  // Keyword narrowing and length count for an appended byte.
  always_comb begin
    base_cand = cont ? cand : '1;
    base_len  = cont ? plen : '0;
    for (int k = 0; k < cst_pkg::NKW; k++) begin
      cand_n[k] = base_cand[k] && (base_len < LENGTH_BITS'(cst_pkg::KW_LEN[k])) &&
                  (cst_pkg::kw_char(k, base_len[2:0]) == in_ch);
    end
    len_inc = (base_len == '1) ? base_len : base_len + LENGTH_BITS'(1);
  end

  // Pending token after the byte.
  always_comb begin
    mode_next = cst_pkg::MODE_IDLE;
    cand_next = '1;
    plen_next = '0;
    if (cont) begin
      mode_next = mode;
      cand_next = cand_n;
      plen_next = len_inc;
    end else if (start_ident || start_num) begin
      mode_next = start_ident ? cst_pkg::MODE_IDENT : cst_pkg::MODE_NUMBER;
      cand_next = cand_n;
      plen_next = len_inc;
    end else if (start_op) begin
      mode_next = cst_pkg::MODE_OP0 + {1'b0, ph.idx};
      plen_next = LENGTH_BITS'(1);
    end
  end

  // Position after the byte, saturating.
  always_comb begin
    line_next = line;
    col_next  = (col == '1) ? col : col + POSITION_BITS'(1);
    if (in_ch == cst_pkg::CH_NEWLINE) begin
      line_next = (line == '1) ? line : line + POSITION_BITS'(1);
      col_next  = POSITION_BITS'(1);
    end
  end

  // Candidate tokens in emission order: old flush, byte's own, new flush, EOF.
  always_comb begin
    t[0].kind = pending_kind(mode, cand, plen);
    t[0].len  = plen;
    t[0].line = line;
    t[0].col  = col;

    t[1].kind = dbl ? cst_pkg::pair_double(op_idx) :
                nul ? cst_pkg::KIND_EOF : cst_pkg::single_kind(in_ch);
    t[1].len  = dbl ? LENGTH_BITS'(2) : (nul ? '0 : LENGTH_BITS'(1));
    t[1].line = nul ? line : line_next;
    t[1].col  = nul ? col : col_next;

    t[2].kind = pending_kind(mode_next, cand_next, plen_next);
    t[2].len  = plen_next;
    t[2].line = line_next;
    t[2].col  = col_next;

    t[3].kind = cst_pkg::KIND_EOF;
    t[3].len  = '0;
    t[3].line = line_next;
    t[3].col  = col_next;

    v[0] = !ended && mode != cst_pkg::MODE_IDLE && !cont && !dbl;
    v[1] = !ended && (dbl || single_tok || nul);
    v[2] = !ended && in_last && !nul && mode_next != cst_pkg::MODE_IDLE;
    v[3] = !ended && in_last && !nul;
  end

  // Pack the valid tokens into consecutive slots.
  always_comb begin
    b.cnt = 2'd0;
    b.tok = '0;
    for (int i = 0; i < 4; i++) begin
      if (v[i]) begin
        case (b.cnt)
          2'd0:    b.tok[0] = t[i];
          2'd1:    b.tok[1] = t[i];
          2'd2:    b.tok[2] = t[i];
          default: b.tok[0] = b.tok[0];
        endcase
        b.cnt = b.cnt + 2'd1;
      end
    end
  end

  assign bundle = b;
  assign push   = accept && b.cnt != 2'd0;

  // State update on each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= cst_pkg::MODE_IDLE;
      cand  <= '1;
      plen  <= '0;
      line  <= POSITION_BITS'(1);
      col   <= POSITION_BITS'(1);
      ended <= 1'b0;
    end else if (accept) begin
      if (ended) begin
        if (in_last) begin
          ended <= 1'b0;
        end
      end else if (nul || in_last) begin
        mode  <= cst_pkg::MODE_IDLE;
        cand  <= '1;
        plen  <= '0;
        line  <= POSITION_BITS'(1);
        col   <= POSITION_BITS'(1);
        ended <= !in_last;
      end else begin
        mode  <= mode_next;
        cand  <= cand_next;
        plen  <= plen_next;
        line  <= line_next;
        col   <= col_next;
      end
    end
  end

  // A last byte always leaves the lexer fresh.
  `CST_ASSERT_NEXT(a_last_resets, clk, rst, accept && in_last, mode == cst_pkg::MODE_IDLE && line == POSITION_BITS'(1) && col == POSITION_BITS'(1) && !ended, "lexer state not reset after last byte")
  // While the rest of a source is dropped, the lexer holds its reset state.
  `CST_ASSERT_IMPLY(a_ended_clean, clk, rst, ended, mode == cst_pkg::MODE_IDLE && line == POSITION_BITS'(1) && col == POSITION_BITS'(1), "dropped source left lexer state")
  // A NUL that is not last starts dropping the source.
  `CST_ASSERT_NEXT(a_nul_ends, clk, rst, accept && !ended && in_ch == cst_pkg::CH_NUL && !in_last, ended, "NUL byte did not end the source")

endmodule

### src/cst_queue.sv
// Short queue of token bundles between the lexer and the output stage.
// Depends on cst_pkg and the assertion macro header.
`include "c_subset_tokenizer_assert.svh"

module cst_queue #(
  parameter int WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               pop,
  output logic [WIDTH-1:0]   rdata,
  output cst_pkg::q_status_t status
);

  logic [WIDTH-1:0]           mem [cst_pkg::Q_DEPTH];
  logic [cst_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [cst_pkg::Q_PTR_W:0]   count;

  assign status.full  = count == (cst_pkg::Q_PTR_W+1)'(cst_pkg::Q_DEPTH);
  assign status.empty = count == '0;
  assign rdata        = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + cst_pkg::Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + cst_pkg::Q_PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (cst_pkg::Q_PTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (cst_pkg::Q_PTR_W+1)'(1);
      end
    end
  end

  `CST_ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && status.full), "push into a full queue")
  `CST_ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && status.empty), "pop from an empty queue")
  `CST_ASSERT_NEXT(a_count_up, clk, rst, push && !pop, count == $past(count) + (cst_pkg::Q_PTR_W+1)'(1), "fill level did not rise on push")

endmodule

### src/cst_back.sv
// Output stage: walks the tokens of the head bundle into a registered stream
// output, one word per cycle unless the output stalls. Depends on cst_pkg.
module cst_back #(
  parameter int LENGTH_BITS   = 12,
  parameter int POSITION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  cst_pkg::q_status_t  q_status,
  input  logic [2+3*(cst_pkg::KIND_W+LENGTH_BITS+2*POSITION_BITS)-1:0] head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [((cst_pkg::KIND_W+LENGTH_BITS+2*POSITION_BITS+7)/8)*8-1:0] out_data,
  output logic                out_last
);

  localparam int TOK_W  = cst_pkg::KIND_W + LENGTH_BITS + 2 * POSITION_BITS;
  localparam int DATA_W = ((TOK_W + 7) / 8) * 8;

  typedef struct packed {
    logic [cst_pkg::KIND_W-1:0] kind;
    logic [LENGTH_BITS-1:0]     len;
    logic [POSITION_BITS-1:0]   line;
    logic [POSITION_BITS-1:0]   col;
  } tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    tok_t [2:0] tok;
  } bundle_t;

  bundle_t    h;
  tok_t       cur;
  logic [1:0] idx;
  logic       load, at_end;

  assign h      = head;
  assign load   = (!out_valid || out_ready) && !q_status.empty;
  assign at_end = idx == h.cnt - 2'd1;
  assign pop    = load && at_end;

  // Token at the walk index.
  always_comb begin
    case (idx)
      2'd1:    cur = h.tok[1];
      2'd2:    cur = h.tok[2];
      default: cur = h.tok[0];
    endcase
  end

  // Walk index and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      idx       <= at_end ? 2'd0 : idx + 2'd1;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output word: col, line, length, kind from the top down.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= DATA_W'({cur.col, cur.line, cur.len, cur.kind});
      out_last <= at_end;
    end
  end

endmodule

### src/c_subset_tokenizer.sv
// Top level of the streaming tokenizer for a small C-like language.
// Depends on cst_pkg, cst_front, cst_queue and cst_back.
//
//  channel  | direction | word contents
//  s_axis   | in        | tdata[7:0] ch; tlast = last byte of the source
//  m_axis   | out       | tdata kind, length, line, column; tlast = end_of_run
//
// One byte is accepted per cycle whenever the token queue has room.
// Each token is sent as its own output word, and a byte may cause up to
// three tokens. A token passes through the bundle queue and the registered
// output stage on its way to m_axis.
// The four-entry bundle queue absorbs output stalls; s_axis_tready drops
// only when it is full. Reset is synchronous and clears all lexer state.
module c_subset_tokenizer #(
  parameter int LENGTH_BITS   = 12,
  parameter int POSITION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] ch
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // token_kind, token_length, line_number, column_number from bit 0 up
  output logic [((cst_pkg::KIND_W+LENGTH_BITS+2*POSITION_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int BUNDLE_W = 2 + 3 * (cst_pkg::KIND_W + LENGTH_BITS + 2 * POSITION_BITS);

  cst_pkg::q_status_t  q_status;
  logic                push, pop;
  logic [BUNDLE_W-1:0] wbundle, rbundle;

  // Lexer front end.
  cst_front #(
    .LENGTH_BITS  (LENGTH_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ch    (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .q_status (q_status),
    .push     (push),
    .bundle   (wbundle)
  );

  // Bundle queue.
  cst_queue #(
    .WIDTH(BUNDLE_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (wbundle),
    .pop    (pop),
    .rdata  (rbundle),
    .status (q_status)
  );

  // Output stage.
  cst_back #(
    .LENGTH_BITS  (LENGTH_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .head      (rbundle),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
